/* design/glyph_layout_with_wrap_top_defines.svh */
// Assertion macros shared by the glyph layout block.
`ifndef GLYPH_LAYOUT_WITH_WRAP_TOP_DEFINES_SVH
`define GLYPH_LAYOUT_WITH_WRAP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GLW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define GLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/glw_pkg.sv */
// Shared types, codes and constants of the glyph layout block.
package glw_pkg;

  localparam int CODE_POINTS_DEF         = 65536;
  localparam int SCALE_FRACTION_BITS_DEF = 8;
  localparam int COORD_BITS_DEF          = 16;

  // Depth of the job queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Width of unscaled-times-scale products and the sizes derived from them.
  localparam int SIZE_W = 17;

  localparam int REG_INDEX_W = 4;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [REG_INDEX_W-1:0] REG_ORIGIN_X   = 4'd0;
  localparam logic [REG_INDEX_W-1:0] REG_ORIGIN_Y   = 4'd1;
  localparam logic [REG_INDEX_W-1:0] REG_WRAP_LIMIT = 4'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SCALE      = 4'd3;

  localparam logic [15:0] ORIGIN_RESET = 16'd0;
  localparam logic [15:0] WRAP_RESET   = 16'd32767;
  localparam logic [11:0] SCALE_RESET  = 12'd256;

  localparam logic [15:0] NEWLINE_CODE = 16'd10;
  localparam logic [14:0] BOX_MAX      = 15'h7FFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] code_point;
    logic        width_bit;
  } item_t;

  typedef struct packed {
    logic               glyph_valid;
    logic [7:0]         atlas_page;
    logic [7:0]         src_x;
    logic [7:0]         src_y;
    logic [4:0]         src_w;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [8:0]         dst_w;
    logic [8:0]         dst_h;
    logic [14:0]        box_right;
    logic [14:0]        box_bottom;
  } result_t;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] wrap_limit;
    logic [11:0] scale;
  } cfg_t;

  // One classified item travelling from the front to the back.
  typedef struct packed {
    logic        is_start;
    logic [15:0] code_point;
    logic        full_width;
  } job_t;

endpackage

/* design/glw_front.sv */
// Front end: accepts items, owns the width table and classifies items into jobs.
module glw_front #(
  parameter int CODE_POINTS = glw_pkg::CODE_POINTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  glw_pkg::item_t  item,
  output logic            push,
  output glw_pkg::job_t   job,
  input  logic            full
);

  localparam int AW = $clog2(CODE_POINTS);

  logic        width_mem [CODE_POINTS];
  logic        rd_bit;
  logic        stage_valid;
  logic [1:0]  stage_action;
  logic [15:0] stage_cp;
  logic        stage_in_range;
  logic        accept;
  logic        in_range;
  logic        needs_queue;
  logic        advance;

  assign in_range    = {1'b0, item.code_point} < 17'(CODE_POINTS);
  assign accept      = item_valid && item_ready;
  assign needs_queue = (stage_action == glw_pkg::ACT_CHAR) ||
                       (stage_action == glw_pkg::ACT_START);
  assign advance     = stage_valid && (!needs_queue || !full);
  assign item_ready  = !stage_valid || advance;
  assign push        = advance && needs_queue;

  // The read is issued only on acceptance, so the data holds while the stage stalls.
  always_ff @(posedge clk) begin
    if (accept && (item.action == glw_pkg::ACT_LOAD) && in_range) begin
      width_mem[item.code_point[AW-1:0]] <= item.width_bit;
    end
    if (accept) begin
      rd_bit <= width_mem[item.code_point[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_action   <= item.action;
      stage_cp       <= item.code_point;
      stage_in_range <= in_range;
    end
  end

  always_comb begin
    job.is_start   = (stage_action == glw_pkg::ACT_START);
    job.code_point = stage_cp;
    job.full_width = stage_in_range && rd_bit;
  end

endmodule

/* design/glw_queue.sv */
// Short job queue that decouples the front end from the layout back end.
module glw_queue #(
  parameter int DEPTH = glw_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  glw_pkg::job_t din,
  input  logic          pop,
  output glw_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);

  glw_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full  = (count == (PW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* design/glw_back.sv */
// Back end: pen tracking with wrap, glyph geometry and the running bounding box.
module glw_back #(
  parameter int SCALE_FRACTION_BITS = glw_pkg::SCALE_FRACTION_BITS_DEF,
  parameter int COORD_BITS          = glw_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  glw_pkg::cfg_t    cfg,
  input  glw_pkg::job_t    job,
  input  logic             empty,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_ready,
  output glw_pkg::result_t result
);

  localparam int F  = SCALE_FRACTION_BITS;
  localparam int CW = COORD_BITS;
  localparam int SW = glw_pkg::SIZE_W;
  localparam int EW = ((CW > SW) ? CW : SW) + 2;

  localparam longint COORD_HI_L = (longint'(1) <<< (CW - 1)) - 1;
  localparam logic signed [EW-1:0] COORD_HI = EW'(COORD_HI_L);
  localparam logic signed [EW-1:0] COORD_LO = EW'(-COORD_HI_L - 1);
  localparam logic signed [EW-1:0] BOX_LIM  = EW'(glw_pkg::BOX_MAX);
  localparam logic [SW-1:0]        ROUND    = SW'((longint'(1) <<< F) - 1);

  function automatic logic signed [CW-1:0] clamp(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > COORD_HI) begin
      r = COORD_HI[CW-1:0];
    end else if (v < COORD_LO) begin
      r = COORD_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [14:0] box_max(input logic [14:0] cur,
                                          input logic signed [EW-1:0] edge_v);
    logic signed [EW-1:0] cur_e;
    logic [14:0]          r;
    cur_e = EW'(cur);
    if (edge_v > cur_e) begin
      r = (edge_v > BOX_LIM) ? glw_pkg::BOX_MAX : edge_v[14:0];
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // Sizes that depend on the scale register alone.
  logic [SW-1:0] wide_half, wide_full, dw_half, dw_full, adv;
  assign wide_half = SW'({cfg.scale, 3'b000});
  assign wide_full = SW'({cfg.scale, 4'b0000});
  assign dw_half   = (wide_half + ROUND) >> F;
  assign dw_full   = (wide_full + ROUND) >> F;
  assign adv       = wide_full >> F;

  logic signed [CW-1:0] org_x, org_y;
  logic signed [EW-1:0] wl_e;
  assign org_x = clamp(EW'($signed(cfg.origin_x)));
  assign org_y = clamp(EW'($signed(cfg.origin_y)));
  assign wl_e  = EW'($signed(cfg.wrap_limit));

  // Pen state, updated as each job leaves the queue.
  logic signed [CW-1:0] pen_x, pen_y;
  logic signed [CW-1:0] pen_x_next, pen_y_next;

  logic [SW-1:0]        dw_sel;
  logic signed [EW-1:0] dw_e, adv_e, sum_x, org_sum;
  logic signed [CW-1:0] y1, y_nl, base_x, base_y, x_glyph;
  logic                 wrap, is_nl;

  assign dw_sel  = job.full_width ? dw_full : dw_half;
  assign dw_e    = EW'(dw_sel);
  assign adv_e   = EW'(adv);
  assign sum_x   = EW'(pen_x) + dw_e;
  assign org_sum = EW'(org_x) + dw_e;
  // With a ceiling width, pen plus width beyond the limit matches the exact product test.
  assign wrap    = sum_x > wl_e;
  assign y1      = clamp(EW'(pen_y) + adv_e);
  assign base_x  = wrap ? org_x : pen_x;
  assign base_y  = wrap ? y1 : pen_y;
  assign y_nl    = clamp(EW'(base_y) + adv_e);
  assign x_glyph = clamp(wrap ? org_sum : sum_x);
  assign is_nl   = (job.code_point == glw_pkg::NEWLINE_CODE);

  always_comb begin
    if (job.is_start) begin
      pen_x_next = org_x;
      pen_y_next = org_y;
    end else if (is_nl) begin
      pen_x_next = org_x;
      pen_y_next = y_nl;
    end else begin
      pen_x_next = x_glyph;
      pen_y_next = base_y;
    end
  end

  // Placement stage between the pen logic and the box logic.
  logic                 b1_valid, b1_start, b1_nl, b1_full;
  logic [15:0]          b1_cp;
  logic signed [CW-1:0] b1_dx, b1_dy;
  logic [SW-1:0]        b1_dw, b1_dh;
  logic                 out_free, b1_adv, b1_load;

  assign out_free = !result_valid || result_ready;
  assign b1_adv   = b1_valid && (b1_start || out_free);
  assign b1_load  = !b1_valid || b1_adv;
  assign pop      = !empty && b1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x    <= '0;
      pen_y    <= '0;
      b1_valid <= 1'b0;
    end else begin
      if (pop) begin
        pen_x <= pen_x_next;
        pen_y <= pen_y_next;
      end
      if (pop) begin
        b1_valid <= 1'b1;
      end else if (b1_adv) begin
        b1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_start <= job.is_start;
      b1_nl    <= is_nl;
      b1_full  <= job.full_width;
      b1_cp    <= job.code_point;
      b1_dx    <= base_x;
      b1_dy    <= base_y;
      b1_dw    <= dw_sel;
      b1_dh    <= dw_full;
    end
  end

  // Bounding box.
  logic [14:0]          right_extent, bottom_extent;
  logic [14:0]          right_new, bottom_new;
  logic signed [EW-1:0] edge_r, edge_b;

  assign edge_r     = EW'(b1_dx) + EW'(b1_dw);
  assign edge_b     = EW'(b1_dy) + EW'(b1_dh);
  assign right_new  = box_max(right_extent, edge_r);
  assign bottom_new = box_max(bottom_extent, edge_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      right_extent  <= '0;
      bottom_extent <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (b1_adv && b1_start) begin
        right_extent  <= '0;
        bottom_extent <= '0;
      end else if (b1_adv && !b1_nl) begin
        right_extent  <= right_new;
        bottom_extent <= bottom_new;
      end
      if (b1_adv && !b1_start) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv && !b1_start) begin
      if (b1_nl) begin
        result <= '0;
      end else begin
        result.glyph_valid <= 1'b1;
        result.atlas_page  <= b1_cp[15:8];
        result.src_x       <= {b1_cp[3:0], 4'b0000};
        result.src_y       <= {b1_cp[7:4], 4'b0000};
        result.src_w       <= b1_full ? 5'd16 : 5'd8;
        result.dst_x       <= 16'(b1_dx);
        result.dst_y       <= 16'(b1_dy);
        result.dst_w       <= b1_dw[8:0];
        result.dst_h       <= b1_dh[8:0];
        result.box_right   <= right_new;
        result.box_bottom  <= bottom_new;
      end
    end
  end

endmodule

/* design/glyph_layout_with_wrap_top.sv */
// Top level of the glyph layout block: configuration registers, front, queue and back.
//
//   Channel   Signals                          Direction   Payload
//   item      item_valid / item_ready          in          glw_pkg::item_t
//   result    result_valid / result_ready      out         glw_pkg::result_t
//   cfg       cfg_valid / cfg_ready            in          cfg_index, cfg_data
//
// One item is accepted per cycle for any mix of loads, starts and characters, as long as
// the result side does not stall. A character's result passes through the width table read,
// a queue slot, the pen placement stage and the box update, which registers the result.
// Loads, starts and unused actions produce no result transaction.
// Reset clears the pen, the box and the pipeline; the width table holds no reset value.
// When the result side stalls, the back end holds and the queue absorbs up to four jobs
// before the item side sees item_ready fall.
`include "glyph_layout_with_wrap_top_defines.svh"

module glyph_layout_with_wrap_top #(
  parameter int CODE_POINTS         = glw_pkg::CODE_POINTS_DEF,
  parameter int SCALE_FRACTION_BITS = glw_pkg::SCALE_FRACTION_BITS_DEF,
  parameter int COORD_BITS          = glw_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  glw_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output glw_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [glw_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  // Configuration registers. The user must make writes arrive only while the block is idle;
  // the block does not enforce it; the back end reads them directly without any shadowing.
  glw_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= glw_pkg::ORIGIN_RESET;
      cfg.origin_y   <= glw_pkg::ORIGIN_RESET;
      cfg.wrap_limit <= glw_pkg::WRAP_RESET;
      cfg.scale      <= glw_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        glw_pkg::REG_ORIGIN_X:   cfg.origin_x   <= cfg_data;
        glw_pkg::REG_ORIGIN_Y:   cfg.origin_y   <= cfg_data;
        glw_pkg::REG_WRAP_LIMIT: cfg.wrap_limit <= cfg_data;
        glw_pkg::REG_SCALE:      cfg.scale      <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // Front to queue, queue to back.
  glw_pkg::job_t q_in;
  glw_pkg::job_t q_out;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  // The front end writes the width table on loads and tags each character
  // with its width before it enters the queue.
  glw_front #(
    .CODE_POINTS (CODE_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (q_push),
    .job        (q_in),
    .full       (q_full)
  );

  glw_queue #(
    .DEPTH (glw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back end keeps the pen and the bounding box and drives the result register.
  glw_back #(
    .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS),
    .COORD_BITS          (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job          (q_out),
    .empty        (q_empty),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The front end never pushes into a full queue, and the back end never pops an empty one.
  `GLW_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "job pushed into a full queue")
  `GLW_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_empty, "job popped from an empty queue")
  // An idle queue stays empty until something is pushed.
  `GLW_ASSERT_NEXT(a_empty_holds, q_empty && !q_push, q_empty, "queue filled without a push")
  // A newline result carries no geometry; a glyph always has a legal source width.
  `GLW_ASSERT_NOW(a_newline_zero, result_valid && !result.glyph_valid,
                  result.dst_w == 9'd0 && result.box_right == 15'd0 &&
                  result.atlas_page == 8'd0, "newline result carries geometry")
  `GLW_ASSERT_NOW(a_src_width, result_valid && result.glyph_valid,
                  result.src_w == 5'd8 || result.src_w == 5'd16, "illegal glyph source width")

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the glyph layout block with line wrap.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import glw_pkg::*;

  // Unused action code; the block must ignore it and send no result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int FRAC_BITS      = SCALE_FRACTION_BITS_DEF;
  localparam int PEN_BITS       = COORD_BITS_DEF;
  // Cycles allowed after the last result for jobs still in flight that make no
  // result: the pipeline stages plus the four-entry job queue, with margin.
  localparam int SETTLE_CYCLES  = 20;
  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [REG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  glyph_layout_with_wrap_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be driven, and glyph results the layout model says must come next.
  item_t   items_to_send[$];
  result_t glyph_queue[$];

  // Layout model state: its own copy of the registers, the width table, the pen and the box.
  logic signed [15:0] cur_origin_x = ORIGIN_RESET;
  logic signed [15:0] cur_origin_y = ORIGIN_RESET;
  logic signed [15:0] cur_wrap     = WRAP_RESET;
  logic [11:0]        cur_scale    = SCALE_RESET;
  bit                 width_tab [0:65535];
  longint             pen_x = 0;
  longint             pen_y = 0;
  longint             right_ext = 0;
  longint             bottom_ext = 0;

  // Stimulus bookkeeping: which width entries have been loaded, so that a character
  // never looks up an entry that was never written.
  bit                 loaded [0:65535];
  logic [15:0]        known_cps[$];

  int  errors = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  // Once set, neither side inserts idle cycles any more.
  bit  quiet = 1'b0;

  // Saturate a pen coordinate to the signed coordinate range.
  function automatic longint sat_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (PEN_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // The box only grows; edges above the box ceiling are held there, and since the
  // box starts at zero, negative edges never pull it below zero.
  function automatic longint grow_box(longint cur, longint edge_pos);
    if (edge_pos > longint'(BOX_MAX)) edge_pos = longint'(BOX_MAX);
    return (edge_pos > cur) ? edge_pos : cur;
  endfunction

  // Apply one accepted item to the layout model and queue the glyph it produces.
  function automatic void lay_out_item(item_t it);
    longint  one, s, adv, srcw, wide, dw, dh, dx, dy;
    result_t r;
    one = longint'(1) <<< FRAC_BITS;
    s   = longint'(cur_scale);
    r   = '0;
    case (it.action)
      ACT_LOAD: begin
        width_tab[it.code_point] = it.width_bit;
      end
      ACT_START: begin
        pen_x      = sat_coord(longint'(cur_origin_x));
        pen_y      = sat_coord(longint'(cur_origin_y));
        right_ext  = 0;
        bottom_ext = 0;
      end
      ACT_CHAR: begin
        adv  = (16 * s) >>> FRAC_BITS;
        srcw = width_tab[it.code_point] ? 16 : 8;
        wide = srcw * s;
        // At most one wrap per character; the glyph is placed afterwards even if
        // it still crosses the limit. The newline takes part in this check too.
        if (pen_x * one + wide > longint'(cur_wrap) * one) begin
          pen_x = sat_coord(longint'(cur_origin_x));
          pen_y = sat_coord(pen_y + adv);
        end
        if (it.code_point == NEWLINE_CODE) begin
          // A newline leaves an all-zero result with glyph_valid low.
          pen_x = sat_coord(longint'(cur_origin_x));
          pen_y = sat_coord(pen_y + adv);
        end else begin
          dw         = (wide + one - 1) >>> FRAC_BITS;
          dh         = (16 * s + one - 1) >>> FRAC_BITS;
          dx         = pen_x;
          dy         = pen_y;
          pen_x      = sat_coord(pen_x + dw);
          right_ext  = grow_box(right_ext, dx + dw);
          bottom_ext = grow_box(bottom_ext, dy + dh);
          r.glyph_valid = 1'b1;
          r.atlas_page  = it.code_point[15:8];
          r.src_x       = {it.code_point[3:0], 4'h0};
          r.src_y       = {it.code_point[7:4], 4'h0};
          r.src_w       = 5'(srcw);
          r.dst_x       = dx[15:0];
          r.dst_y       = dy[15:0];
          r.dst_w       = dw[8:0];
          r.dst_h       = dh[8:0];
          r.box_right   = right_ext[14:0];
          r.box_bottom  = bottom_ext[14:0];
        end
        glyph_queue = {glyph_queue, r};
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic compare_glyph(result_t got);
    result_t want;
    want = glyph_queue.pop_front();
    check_field("glyph_valid", want.glyph_valid, got.glyph_valid);
    check_field("atlas_page",  want.atlas_page,  got.atlas_page);
    check_field("src_x",       want.src_x,       got.src_x);
    check_field("src_y",       want.src_y,       got.src_y);
    check_field("src_w",       want.src_w,       got.src_w);
    check_field("dst_x",       want.dst_x,       got.dst_x);
    check_field("dst_y",       want.dst_y,       got.dst_y);
    check_field("dst_w",       want.dst_w,       got.dst_w);
    check_field("dst_h",       want.dst_h,       got.dst_h);
    check_field("box_right",   want.box_right,   got.box_right);
    check_field("box_bottom",  want.box_bottom,  got.box_bottom);
  endtask

  // Item driver. A new item is presented only when the slot is free, that is when
  // nothing is shown or the shown item is taken at this edge. Idle bursts fall between
  // items at random.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        lay_out_item(item);
      end
      if (!item_valid || item_ready) begin
        if (gap_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 4);
        end
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          item       <= items_to_send.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every result transaction is checked against the oldest queued
  // glyph; result_ready drops in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (glyph_queue.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual %p", $time, result);
          errors++;
        end else begin
          compare_glyph(result);
        end
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no transaction on any channel means the block hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 glyph_queue.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic void add_item(logic [1:0] act, logic [15:0] cp, logic wb);
    item_t it;
    it.action     = act;
    it.code_point = cp;
    it.width_bit  = wb;
    items_to_send = {items_to_send, it};
  endfunction

  function automatic void add_load(logic [15:0] cp, logic wb);
    add_item(ACT_LOAD, cp, wb);
    if (!loaded[cp]) begin
      loaded[cp] = 1'b1;
      known_cps  = {known_cps, cp};
    end
  endfunction

  // Characters come only from loaded entries; about one in ten is a newline.
  function automatic logic [15:0] pick_char();
    if ($urandom_range(0, 9) == 0) return NEWLINE_CODE;
    return known_cps[$urandom_range(0, known_cps.size() - 1)];
  endfunction

  // Random traffic: mostly text runs (start, then characters with the odd load mixed
  // in), plus bursts of loads, unused actions and characters with no start first.
  // Unused actions do not count toward the item budget.
  function automatic void gen_items(int budget);
    int made, pick, k, len;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_item(ACT_START, 16'($urandom), 1'($urandom));
        made++;
        len = $urandom_range(3, 20);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            add_load(16'($urandom), 1'($urandom));
          end else begin
            add_item(ACT_CHAR, pick_char(), 1'($urandom));
          end
          made++;
        end
      end else if (pick < 85) begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 1) == 0) begin
            add_load(16'($urandom), 1'($urandom));
          end else begin
            add_load(known_cps[$urandom_range(0, known_cps.size() - 1)], 1'($urandom));
          end
          made++;
        end
      end else if (pick < 92) begin
        add_item(ACT_UNUSED, 16'($urandom), 1'($urandom));
      end else begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          add_item(ACT_CHAR, pick_char(), 1'($urandom));
          made++;
        end
      end
    end
  endfunction

  // One register write transaction; the layout model takes the value on acceptance.
  // Indexes past the last register are ignored by the block and by the model.
  task automatic write_reg(logic [REG_INDEX_W-1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_ORIGIN_X: begin
        cur_origin_x = data;
      end
      REG_ORIGIN_Y: begin
        cur_origin_y = data;
      end
      REG_WRAP_LIMIT: begin
        cur_wrap = data;
      end
      REG_SCALE: begin
        cur_scale = data[11:0];
      end
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Hold off until every item is in and every glyph is out, then give the pipeline
  // time to retire trailing loads and starts that make no result.
  task automatic drain();
    while (items_to_send.size() != 0 || item_valid || glyph_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram all registers on an idle block, then queue a batch of random items.
  // The upper nibble of the scale write is junk that the block must drop.
  task automatic run_phase(logic [15:0] ox, logic [15:0] oy, logic [15:0] wl,
                           logic [11:0] sc, int budget);
    logic [15:0] scale_word;
    drain();
    scale_word       = 16'($urandom);
    scale_word[11:0] = sc;
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_WRAP_LIMIT, wl);
    write_reg(REG_SCALE, scale_word);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_INDEX_W'($urandom_range(4, 15)), 16'($urandom));
    end
    gen_items(budget);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with registers at their reset values: width loads at the
    // code point extremes and for the newline, a run with half and full width
    // glyphs, a newline, an unused action that must vanish, and a width rewrite.
    add_load(16'h0000, 1'b0);
    add_load(16'hFFFF, 1'b1);
    add_load(NEWLINE_CODE, 1'b0);
    add_load(16'h0041, 1'b0);
    add_load(16'h4E2D, 1'b1);
    add_load(16'hA5F3, 1'b1);
    add_item(ACT_START, 16'hFFFF, 1'b1);
    add_item(ACT_CHAR, 16'h0000, 1'b1);
    add_item(ACT_CHAR, 16'hFFFF, 1'b0);
    add_item(ACT_CHAR, 16'h0041, 1'b0);
    add_item(ACT_CHAR, 16'h4E2D, 1'b0);
    add_item(ACT_CHAR, NEWLINE_CODE, 1'b1);
    add_item(ACT_CHAR, 16'hA5F3, 1'b0);
    add_item(ACT_UNUSED, 16'hFFFF, 1'b1);
    add_load(16'h0041, 1'b1);
    add_item(ACT_CHAR, 16'h0041, 1'b0);
    add_item(ACT_START, 16'h0000, 1'b0);
    add_item(ACT_CHAR, 16'hFFFF, 1'b1);
    add_item(ACT_CHAR, NEWLINE_CODE, 1'b0);

    // Plain layout at unit scale, then ordinary wrapping on a narrow line.
    run_phase(16'sd0, 16'sd0, 16'sd32767, 12'd256, 110);
    run_phase(16'sd100, 16'sd50, 16'sd400, 12'd256, 110);
    // A line too narrow for any glyph: every character wraps once and is placed anyway.
    run_phase(16'sd0, 16'sd0, 16'sd0, 12'd256, 110);
    // Largest scale at the positive corner: pen x and pen y saturate high.
    run_phase(16'sd32767, 16'sd32767, 16'sd32767, 12'd4095, 110);
    // Negative corner: negative edges must not pull the box below zero.
    run_phase(-16'sd32768, -16'sd32768, -16'sd32000, 12'd4095, 110);
    // Smallest nonzero scale, then a scale of zero with zero sizes and no advance.
    run_phase(-16'sd50, -16'sd20, 16'sd200, 12'd1, 110);
    run_phase(16'sd0, 16'sd0, 16'sd300, 12'd0, 110);
    // Pen y close to the top, so that line advances saturate.
    run_phase(-16'sd100, 16'sd32700, 16'sd100, 12'd640, 110);
    // Random register settings.
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom_range(1, 4095)), 110);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom_range(1, 4095)), 110);
    // The last batch runs at full rate on both sides.
    drain();
    quiet = 1'b1;
    run_phase(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(2000, 8000)), 12'($urandom_range(64, 1024)), 110);

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
